FILE: sv/scp_pkg.sv
`default_nettype none
package scp_pkg;

   localparam int unsigned RegionCountMax = 8;
   localparam logic [31:0] MainIdReset    = 32'h4105_9461;
   localparam logic [31:0] ControlReset   = 32'h0F0D_2112;
   localparam logic [31:0] BaseMask       = 32'hFFFF_F000;
   localparam logic [31:0] DtcmBaseReset  = 32'h0080_0000;
   localparam logic [4:0]  ItcmCodeReset  = 5'd6;
   localparam logic [4:0]  DtcmCodeReset  = 5'd5;
   localparam int unsigned QueueDepth     = 2;

   // Decoded operation carried from the front to the back.
   typedef enum logic [3:0] {
      OP_NONE,
      OP_RD_ID,
      OP_RD_CTRL,
      OP_RD_PERM,
      OP_RD_DTCM,
      OP_RD_ITCM,
      OP_WR_CTRL,
      OP_WR_PERM,
      OP_WR_REGION,
      OP_WR_DTCM,
      OP_WR_ITCM,
      OP_HALT
   } op_type;

   typedef struct packed {
      op_type      op;
      logic [2:0]  sel;
      logic [31:0] data;
   } cmd_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DONE
   } state_type;

   // TCM end: base + (512 << code, zero if code >= 23), mod 2^32, or zero if TCM is off.
   function automatic logic [31:0] mem_limit(input logic on, input logic [31:0] base,
                                             input logic [4:0] code);
      logic [31:0] size;
      begin
         size = 32'd0;
         if (code < 5'd23) begin
            size = 32'd512 << code;
         end
         mem_limit = on ? base + size : 32'd0;
      end
   endfunction

endpackage
`default_nettype wire

FILE: sv/scp_front.sv
`default_nettype none
module scp_front #(
   parameter int unsigned QDEPTH = scp_pkg::QueueDepth
) (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            req_push,
   output logic                 req_full,
   input  wire logic            req_type,
   input  wire logic [3:0]      req_reg_major,
   input  wire logic [3:0]      req_reg_minor,
   input  wire logic [2:0]      req_op_variant,
   input  wire logic [31:0]     req_write_data,
   output logic                 cmd_valid,
   output scp_pkg::cmd_type     cmd,
   input  wire logic            cmd_take
);

   localparam int unsigned PW = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;

   scp_pkg::cmd_type             queue_ff [QDEPTH];
   logic [PW-1:0]                wptr_ff, wptr_in, rptr_ff, rptr_in;
   logic [PW:0]                  count_ff, count_in;
   scp_pkg::cmd_type             dec;
   logic                         push_ok;

   // Decode the access into one operation.
   always_comb begin
      dec.op   = scp_pkg::OP_NONE;
      dec.sel  = req_op_variant;
      dec.data = req_write_data;
      if (req_type) begin
         unique case (req_reg_major)
            4'd1: if (req_reg_minor == 4'd0 && req_op_variant == 3'd0)
                     dec.op = scp_pkg::OP_WR_CTRL;
            4'd5: dec.op = scp_pkg::OP_WR_PERM;
            4'd6: begin
               dec.op  = scp_pkg::OP_WR_REGION;
               dec.sel = req_reg_minor[2:0];
            end
            4'd7: if ((req_reg_minor == 4'd0 && req_op_variant == 3'd4) ||
                      (req_reg_minor == 4'd8 && req_op_variant == 3'd2))
                     dec.op = scp_pkg::OP_HALT;
            4'd9: if (req_reg_minor == 4'd1 && req_op_variant == 3'd0)
                     dec.op = scp_pkg::OP_WR_DTCM;
                  else if (req_reg_minor == 4'd1 && req_op_variant == 3'd1)
                     dec.op = scp_pkg::OP_WR_ITCM;
            4'd15: if (req_reg_minor == 4'd8 && req_op_variant == 3'd2)
                     dec.op = scp_pkg::OP_HALT;
            default: dec.op = scp_pkg::OP_NONE;
         endcase
      end else begin
         unique case (req_reg_major)
            4'd0: dec.op = (req_op_variant == 3'd1) ? scp_pkg::OP_RD_CTRL
                                                    : scp_pkg::OP_RD_ID;
            4'd1: if (req_reg_minor == 4'd0 && req_op_variant == 3'd0)
                     dec.op = scp_pkg::OP_RD_CTRL;
            4'd5: dec.op = scp_pkg::OP_RD_PERM;
            4'd9: if (req_reg_minor == 4'd1 && req_op_variant == 3'd0)
                     dec.op = scp_pkg::OP_RD_DTCM;
                  else if (req_reg_minor == 4'd1 && req_op_variant == 3'd1)
                     dec.op = scp_pkg::OP_RD_ITCM;
            default: dec.op = scp_pkg::OP_NONE;
         endcase
      end
   end

   assign req_full  = (count_ff == (PW+1)'(QDEPTH));
   assign push_ok   = req_push && !req_full;
   assign cmd_valid = (count_ff != '0);
   assign cmd       = queue_ff[rptr_ff];

   // Pointer and count update for the command queue.
   always_comb begin
      wptr_in  = wptr_ff;
      rptr_in  = rptr_ff;
      count_in = count_ff;
      if (push_ok) begin
         wptr_in = (wptr_ff == PW'(QDEPTH-1)) ? '0 : wptr_ff + 1'b1;
      end
      if (cmd_take && cmd_valid) begin
         rptr_in = (rptr_ff == PW'(QDEPTH-1)) ? '0 : rptr_ff + 1'b1;
      end
      if (push_ok && !(cmd_take && cmd_valid)) begin
         count_in = count_ff + 1'b1;
      end else if (!push_ok && cmd_take && cmd_valid) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff  <= '0;
         rptr_ff  <= '0;
         count_ff <= '0;
      end else begin
         wptr_ff  <= wptr_in;
         rptr_ff  <= rptr_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_ok) begin
         queue_ff[wptr_ff] <= dec;
      end
   end

endmodule
`default_nettype wire

FILE: sv/scp_back.sv
`default_nettype none
module scp_back #(
   parameter int unsigned REGION_COUNT = scp_pkg::RegionCountMax
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             cmd_valid,
   input  scp_pkg::cmd_type      cmd,
   output logic                  cmd_take,
   input  wire logic [31:0]      main_id,
   output logic                  rsp_empty,
   input  wire logic             rsp_pop,
   output logic [31:0]           rsp_read_data,
   output logic                  rsp_halt_request,
   output logic [31:0]           rsp_itcm_limit,
   output logic [31:0]           rsp_dtcm_limit,
   output logic [31:0]           rsp_itcm_guard_start,
   output logic [31:0]           rsp_itcm_guard_end
);

   localparam int unsigned RW = (REGION_COUNT > 1) ? $clog2(REGION_COUNT) : 1;

   scp_pkg::state_type state_ff, state_in;
   logic [31:0] control_ff;
   logic [31:0] perm_ff [4];
   logic [31:0] rbase_ff [REGION_COUNT];
   logic [31:0] rlast_ff [REGION_COUNT];
   logic [31:0] ibase_ff, dbase_ff;
   logic [4:0]  icode_ff, dcode_ff;
   logic        ion_ff, don_ff;
   logic [31:0] glo_ff, ghi_ff;
   logic [31:0] lo_ff, hi_ff, lim_ff;
   logic [RW-1:0] idx_ff;
   logic        out_valid_ff;
   logic [31:0] rd_ff;
   logic        halt_ff;

   logic        start_scan, last_idx, hit;
   logic [31:0] rd_val, cur_base, cur_last;
   logic [31:0] ilim_new, ilim_now;
   logic [4:0]  n_code;
   logic [31:0] bitn, amask, newbase;
   logic [RW-1:0] widx;
   logic        in_range;

   assign ilim_now = scp_pkg::mem_limit(ion_ff, ibase_ff, icode_ff);

   // The back takes one command when idle and the result slot is free.
   assign cmd_take = (state_ff == scp_pkg::ST_IDLE) && cmd_valid && !out_valid_ff;
   assign start_scan = cmd_take && (cmd.op == scp_pkg::OP_WR_CTRL ||
                                    cmd.op == scp_pkg::OP_WR_ITCM);

   // Instruction TCM limit after the command's own update.
   always_comb begin
      ilim_new = ilim_now;
      if (cmd.op == scp_pkg::OP_WR_CTRL) begin
         ilim_new = scp_pkg::mem_limit(cmd.data[18], ibase_ff, icode_ff);
      end else if (cmd.op == scp_pkg::OP_WR_ITCM) begin
         ilim_new = scp_pkg::mem_limit(ion_ff, cmd.data & scp_pkg::BaseMask,
                                       cmd.data[5:1]);
      end
   end

   // Region write checks.
   assign n_code   = cmd.data[5:1];
   assign widx     = RW'(cmd.sel);
   assign in_range = (n_code > 5'd10) && (n_code < 5'd28);
   assign newbase  = cmd.data & scp_pkg::BaseMask;
   assign bitn     = 32'd1 << n_code;
   assign amask    = bitn | ((bitn - 32'd1) & scp_pkg::BaseMask);

   // Read value.
   always_comb begin
      case (cmd.op)
         scp_pkg::OP_RD_ID:   rd_val = main_id;
         scp_pkg::OP_RD_CTRL: rd_val = control_ff;
         scp_pkg::OP_RD_PERM: rd_val = perm_ff[cmd.sel[1:0]];
         scp_pkg::OP_RD_DTCM: rd_val = dbase_ff | {26'd0, dcode_ff, 1'b0};
         scp_pkg::OP_RD_ITCM: rd_val = ibase_ff | {26'd0, icode_ff, 1'b0};
         default:             rd_val = 32'd0;
      endcase
   end

   // One region per cycle during the guard scan.
   assign cur_base = rbase_ff[idx_ff];
   assign cur_last = rlast_ff[idx_ff];
   assign hit      = (cur_base != 32'd0) && (cur_last < lim_ff);
   assign last_idx = (idx_ff == RW'(REGION_COUNT-1));

   // Next state. The scan runs when the control bit in force after the
   // command is set.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         scp_pkg::ST_IDLE: if (start_scan) begin
            state_in = ((cmd.op == scp_pkg::OP_WR_CTRL) ? cmd.data[0] : control_ff[0]) ?
                       scp_pkg::ST_SCAN : scp_pkg::ST_IDLE;
         end
         scp_pkg::ST_SCAN: if (last_idx) state_in = scp_pkg::ST_DONE;
         scp_pkg::ST_DONE: state_in = scp_pkg::ST_IDLE;
         default:          state_in = scp_pkg::ST_IDLE;
      endcase
   end

   // Outputs of the state machine.
   always_comb begin
      rsp_empty = !out_valid_ff || (state_ff != scp_pkg::ST_IDLE);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= scp_pkg::ST_IDLE;
         out_valid_ff <= 1'b0;
         control_ff   <= scp_pkg::ControlReset;
         for (int i = 0; i < 4; i++) perm_ff[i] <= 32'd0;
         for (int i = 0; i < REGION_COUNT; i++) begin
            rbase_ff[i] <= 32'd0;
            rlast_ff[i] <= 32'd0;
         end
         ibase_ff <= 32'd0;
         icode_ff <= scp_pkg::ItcmCodeReset;
         dbase_ff <= scp_pkg::DtcmBaseReset;
         dcode_ff <= scp_pkg::DtcmCodeReset;
         ion_ff   <= 1'b1;
         don_ff   <= 1'b1;
         glo_ff   <= 32'd0;
         ghi_ff   <= 32'd0;
         idx_ff   <= '0;
      end else begin
         state_ff <= state_in;
         if (rsp_pop && !rsp_empty) begin
            out_valid_ff <= 1'b0;
         end
         if (cmd_take) begin
            out_valid_ff <= 1'b1;
            case (cmd.op)
               scp_pkg::OP_WR_CTRL: begin
                  control_ff <= cmd.data;
                  don_ff     <= cmd.data[16];
                  ion_ff     <= cmd.data[18];
               end
               scp_pkg::OP_WR_PERM: perm_ff[cmd.sel[1:0]] <= cmd.data;
               scp_pkg::OP_WR_REGION: begin
                  if (32'(cmd.sel) < REGION_COUNT && in_range) begin
                     rbase_ff[widx] <= newbase;
                     if ((cmd.data & amask) == 32'd0) begin
                        rlast_ff[widx] <= newbase + ((bitn << 1) - 32'd1);
                     end
                  end
               end
               scp_pkg::OP_WR_DTCM: begin
                  dbase_ff <= newbase;
                  dcode_ff <= cmd.data[5:1];
               end
               scp_pkg::OP_WR_ITCM: begin
                  ibase_ff <= newbase;
                  icode_ff <= cmd.data[5:1];
               end
               default: ;
            endcase
            if (start_scan) begin
               glo_ff <= 32'd0;
               ghi_ff <= ilim_new;
               lim_ff <= ilim_new;
               lo_ff  <= 32'hFFFF_FFFF;
               hi_ff  <= 32'd0;
               idx_ff <= '0;
            end
         end
         if (state_ff == scp_pkg::ST_SCAN) begin
            if (hit && cur_base < lo_ff) lo_ff <= cur_base;
            if (hit && cur_last > hi_ff) hi_ff <= cur_last;
            idx_ff <= idx_ff + 1'b1;
         end
         if (state_ff == scp_pkg::ST_DONE && hi_ff != 32'd0) begin
            glo_ff <= lo_ff;
            ghi_ff <= hi_ff;
         end
      end
   end

   // Result register, captured with the command.
   always_ff @(posedge clock) begin
      if (cmd_take) begin
         rd_ff   <= rd_val;
         halt_ff <= (cmd.op == scp_pkg::OP_HALT);
      end
   end

   assign rsp_read_data        = rd_ff;
   assign rsp_halt_request     = halt_ff;
   assign rsp_itcm_limit       = ilim_now;
   assign rsp_dtcm_limit       = scp_pkg::mem_limit(don_ff, dbase_ff, dcode_ff);
   assign rsp_itcm_guard_start = glo_ff;
   assign rsp_itcm_guard_end   = ghi_ff;

endmodule
`default_nettype wire

FILE: sv/system_control_coprocessor_mpu_tcm.sv
`default_nettype none
// Protection unit and TCM register block of a system control coprocessor.
// Requests enter through a queue interface: drive the access fields and
// raise req_push; the request is taken at an edge where req_full is low.
// A small decoded-command queue separates the decoder from the register
// back end, so the decoder keeps taking requests while the back end works.
// Results leave as a queue: while rsp_empty is low the oldest result is on
// the rsp_ ports; rsp_pop takes it. A stalled receiver simply leaves the
// result held, and the back end then stops; requests still fill the
// command queue until req_full rises.
// A request passes through the command queue and then the result register.
// A control write or instruction TCM write with the protection unit on
// runs a guard scan over the regions, one region a cycle, before its result
// shows. The back end takes no new request until its single result register
// has been popped. Reset restores the documented register values; the user
// must write the identification word through the csr_ channel while the
// block is idle. The block itself does not enforce this.
module system_control_coprocessor_mpu_tcm #(
   parameter int unsigned REGION_COUNT = scp_pkg::RegionCountMax
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_push,
   output logic             req_full,
   input  wire logic        req_type,
   input  wire logic [3:0]  req_reg_major,
   input  wire logic [3:0]  req_reg_minor,
   input  wire logic [2:0]  req_op_variant,
   input  wire logic [31:0] req_write_data,
   output logic             rsp_empty,
   input  wire logic        rsp_pop,
   output logic [31:0]      rsp_read_data,
   output logic             rsp_halt_request,
   output logic [31:0]      rsp_itcm_limit,
   output logic [31:0]      rsp_dtcm_limit,
   output logic [31:0]      rsp_itcm_guard_start,
   output logic [31:0]      rsp_itcm_guard_end,
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [31:0] csr_data
);

   logic             cmd_valid, cmd_take;
   scp_pkg::cmd_type cmd;
   logic [31:0]      main_id_ff;

   // Identification register.
   assign csr_ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         main_id_ff <= scp_pkg::MainIdReset;
      end else if (csr_valid && csr_ready) begin
         main_id_ff <= csr_data;
      end
   end

   scp_front u_front (
      .clock, .reset, .req_push, .req_full, .req_type, .req_reg_major,
      .req_reg_minor, .req_op_variant, .req_write_data,
      .cmd_valid, .cmd, .cmd_take
   );

   scp_back #(.REGION_COUNT(REGION_COUNT)) u_back (
      .clock, .reset, .cmd_valid, .cmd, .cmd_take, .main_id(main_id_ff),
      .rsp_empty, .rsp_pop, .rsp_read_data, .rsp_halt_request,
      .rsp_itcm_limit, .rsp_dtcm_limit, .rsp_itcm_guard_start,
      .rsp_itcm_guard_end
   );

   // A halt result never carries read data.
   a_halt_no_data: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_halt_request) |-> (rsp_read_data == 32'd0))
      else $error("halt result with read data");

   // A shown result stays until popped.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && !rsp_pop) |=> (!rsp_empty && $stable(rsp_read_data)))
      else $error("result changed while stalled");

   // With a zero ITCM limit, guard start is zero or guard end nonzero.
   a_guard_lim: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_itcm_limit == 32'd0) |->
      (rsp_itcm_guard_start == 32'd0 || rsp_itcm_guard_end != 32'd0))
      else $error("guard window inconsistent");

endmodule
`default_nettype wire
